@@ src/qgbq_pkg.sv @@
// ----------------------------------------------------------------------------
// qgbq_pkg
// Shared types, weights, glyph table and small constant dividers for the
// quadrant glyph block quantizer.
// ----------------------------------------------------------------------------
package qgbq_pkg;

	localparam int LumaW = 18;   // widest luma sum: 255 * 1024
	localparam int SumW  = 20;   // four luma values
	localparam int CntW  = 3;    // 0..4 pixels
	localparam int ChW   = 10;   // four 8-bit channel values

	// mean luma weights
	localparam logic [LumaW-1:0] MeanWr = 18'd218;
	localparam logic [LumaW-1:0] MeanWg = 18'd732;
	localparam logic [LumaW-1:0] MeanWb = 18'd74;
	// pixel luma weights
	localparam logic [LumaW-1:0] PixWr  = 18'd299;
	localparam logic [LumaW-1:0] PixWg  = 18'd587;
	localparam logic [LumaW-1:0] PixWb  = 18'd114;

	// reciprocals of three: exact below 2^21 and 2^11 respectively
	localparam logic [40:0] RecipMean = 41'd699051;
	localparam logic [20:0] RecipChan = 21'd683;

	localparam logic [3:0] PatNone = 4'd0;
	localparam logic [3:0] PatFull = 4'd15;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} px_t;

	// after luma weighting
	typedef struct packed {
		px_t [3:0]              px;
		logic [3:0]             mask;
		logic [3:0][LumaW-1:0]  ym;
		logic [3:0][LumaW-1:0]  yl;
	} luma_t;

	// after masked sum
	typedef struct packed {
		px_t [3:0]              px;
		logic [3:0]             mask;
		logic [3:0][LumaW-1:0]  yl;
		logic [SumW-1:0]        sum;
		logic [CntW-1:0]        cnt;
	} msum_t;

	// after mean division
	typedef struct packed {
		px_t [3:0]              px;
		logic [3:0]             mask;
		logic [3:0][LumaW-1:0]  yl;
		logic [LumaW-1:0]       mean;
	} mean_t;

	// after foreground / background split
	typedef struct packed {
		logic [3:0]             pattern;
		logic [2:0][ChW-1:0]    fg_sum;   // r, g, b
		logic [2:0][ChW-1:0]    bg_sum;
		logic [CntW-1:0]        fg_n;
		logic [CntW-1:0]        bg_n;
	} split_t;

	// result cell
	typedef struct packed {
		logic [13:0] glyph;
		logic [3:0]  pattern;
		px_t         fg;
		px_t         bg;
	} cell_t;

	// quadrant block code points
	function automatic logic [13:0] glyph_of(input logic [3:0] pat);
		logic [13:0] code;
		case (pat)
			4'd0:    code = 14'h0020;
			4'd1:    code = 14'h2598;
			4'd2:    code = 14'h259D;
			4'd3:    code = 14'h2580;
			4'd4:    code = 14'h2596;
			4'd5:    code = 14'h258C;
			4'd6:    code = 14'h259E;
			4'd7:    code = 14'h259B;
			4'd8:    code = 14'h2597;
			4'd9:    code = 14'h259A;
			4'd10:   code = 14'h2590;
			4'd11:   code = 14'h259C;
			4'd12:   code = 14'h2584;
			4'd13:   code = 14'h2599;
			4'd14:   code = 14'h259F;
			default: code = 14'h2588;
		endcase
		return code;
	endfunction

	// luma sum over 1..4 pixels divided by the pixel count
	function automatic logic [LumaW-1:0] mean_div(input logic [SumW-1:0] sum,
		input logic [CntW-1:0] cnt);
		logic [40:0]      prod;
		logic [LumaW-1:0] q;
		prod = 41'(sum) * RecipMean;
		case (cnt)
			3'd1:    q = sum[17:0];
			3'd2:    q = sum[18:1];
			3'd3:    q = prod[38:21];
			3'd4:    q = sum[19:2];
			default: q = '0;
		endcase
		return q;
	endfunction

	// channel sum over 1..4 pixels divided by the pixel count
	function automatic logic [7:0] chan_div(input logic [ChW-1:0] sum,
		input logic [CntW-1:0] cnt);
		logic [20:0] prod;
		logic [7:0]  q;
		prod = 21'(sum) * RecipChan;
		case (cnt)
			3'd1:    q = sum[7:0];
			3'd2:    q = sum[8:1];
			3'd3:    q = prod[18:11];
			3'd4:    q = sum[9:2];
			default: q = '0;
		endcase
		return q;
	endfunction

endpackage

@@ src/qgbq_luma.sv @@
// ----------------------------------------------------------------------------
// qgbq_luma
// Stage 1: drops blocks with an empty mask and weighs every pixel with both
// luma weight sets.
// ----------------------------------------------------------------------------
module qgbq_luma (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  qgbq_pkg::px_t [3:0] in_px,
	input  logic [3:0]          in_mask,
	output logic                out_valid,
	input  logic                out_ready,
	output qgbq_pkg::luma_t     out_data
);

	logic            valid_s1;
	qgbq_pkg::luma_t data_s1;
	qgbq_pkg::luma_t data_d;
	logic            keep;

	assign in_ready = !valid_s1 || out_ready;
	assign keep     = in_valid && (in_mask != 4'd0);

	// constant-weight products per pixel
	always_comb begin
		data_d.px   = in_px;
		data_d.mask = in_mask;
		for (int i = 0; i < 4; i++) begin
			data_d.ym[i] = 18'(in_px[i].r) * qgbq_pkg::MeanWr
				+ 18'(in_px[i].g) * qgbq_pkg::MeanWg
				+ 18'(in_px[i].b) * qgbq_pkg::MeanWb;
			data_d.yl[i] = 18'(in_px[i].r) * qgbq_pkg::PixWr
				+ 18'(in_px[i].g) * qgbq_pkg::PixWg
				+ 18'(in_px[i].b) * qgbq_pkg::PixWb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && keep) begin
			data_s1 <= data_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

@@ src/qgbq_mean.sv @@
// ----------------------------------------------------------------------------
// qgbq_mean
// Stages 2 and 3: masked luma sum with pixel count, then division of the sum
// by the count (shift, or reciprocal multiply for three pixels).
// ----------------------------------------------------------------------------
module qgbq_mean (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  qgbq_pkg::luma_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output qgbq_pkg::mean_t out_data
);

	logic            valid_s2, valid_s3;
	logic            ready_s3;
	qgbq_pkg::msum_t data_s2, sum_d;
	qgbq_pkg::mean_t data_s3, mean_d;

	assign ready_s3 = !valid_s3 || out_ready;
	assign in_ready = !valid_s2 || ready_s3;

	// masked sum and count
	always_comb begin
		sum_d.px   = in_data.px;
		sum_d.mask = in_data.mask;
		sum_d.yl   = in_data.yl;
		sum_d.sum  = '0;
		for (int i = 0; i < 4; i++) begin
			if (in_data.mask[i]) begin
				sum_d.sum = sum_d.sum + qgbq_pkg::SumW'(in_data.ym[i]);
			end
		end
		sum_d.cnt = qgbq_pkg::CntW'($countones(in_data.mask));
	end

	// truncated mean
	always_comb begin
		mean_d.px   = data_s2.px;
		mean_d.mask = data_s2.mask;
		mean_d.yl   = data_s2.yl;
		mean_d.mean = qgbq_pkg::mean_div(data_s2.sum, data_s2.cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= sum_d;
		end
		if (ready_s3 && valid_s2) begin
			data_s3 <= mean_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

@@ src/qgbq_split.sv @@
// ----------------------------------------------------------------------------
// qgbq_split
// Stage 4: compares each valid pixel against the mean and accumulates the
// channel sums and pixel counts of the bright and dark groups.
// ----------------------------------------------------------------------------
module qgbq_split (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qgbq_pkg::mean_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output qgbq_pkg::split_t out_data
);

	logic             valid_s4;
	qgbq_pkg::split_t data_s4, split_d;
	logic [3:0]       bright;

	assign in_ready = !valid_s4 || out_ready;

	// per-pixel threshold and group sums
	always_comb begin
		split_d = '0;
		for (int i = 0; i < 4; i++) begin
			bright[i] = in_data.mask[i] && (in_data.yl[i] >= in_data.mean);
		end
		split_d.pattern = bright;
		for (int i = 0; i < 4; i++) begin
			if (bright[i]) begin
				split_d.fg_sum[2] = split_d.fg_sum[2] + qgbq_pkg::ChW'(in_data.px[i].r);
				split_d.fg_sum[1] = split_d.fg_sum[1] + qgbq_pkg::ChW'(in_data.px[i].g);
				split_d.fg_sum[0] = split_d.fg_sum[0] + qgbq_pkg::ChW'(in_data.px[i].b);
				split_d.fg_n      = split_d.fg_n + 3'd1;
			end else if (in_data.mask[i]) begin
				split_d.bg_sum[2] = split_d.bg_sum[2] + qgbq_pkg::ChW'(in_data.px[i].r);
				split_d.bg_sum[1] = split_d.bg_sum[1] + qgbq_pkg::ChW'(in_data.px[i].g);
				split_d.bg_sum[0] = split_d.bg_sum[0] + qgbq_pkg::ChW'(in_data.px[i].b);
				split_d.bg_n      = split_d.bg_n + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s4 <= split_d;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

@@ src/qgbq_color.sv @@
// ----------------------------------------------------------------------------
// qgbq_color
// Stage 5: channel means of both groups, empty-group substitution, glyph
// lookup. Its register is the output register of the block.
// ----------------------------------------------------------------------------
module qgbq_color (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qgbq_pkg::split_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output qgbq_pkg::cell_t  out_data
);

	logic            valid_s5;
	qgbq_pkg::cell_t data_s5, cell_d;
	qgbq_pkg::px_t   fg_mean, bg_mean;
	logic [3:0]      pat;

	assign in_ready = !valid_s5 || out_ready;

	// group means; a count of zero yields zero
	always_comb begin
		fg_mean.r = qgbq_pkg::chan_div(in_data.fg_sum[2], in_data.fg_n);
		fg_mean.g = qgbq_pkg::chan_div(in_data.fg_sum[1], in_data.fg_n);
		fg_mean.b = qgbq_pkg::chan_div(in_data.fg_sum[0], in_data.fg_n);
		bg_mean.r = qgbq_pkg::chan_div(in_data.bg_sum[2], in_data.bg_n);
		bg_mean.g = qgbq_pkg::chan_div(in_data.bg_sum[1], in_data.bg_n);
		bg_mean.b = qgbq_pkg::chan_div(in_data.bg_sum[0], in_data.bg_n);
	end

	// one-sided blocks copy the other color and go blank or full
	always_comb begin
		pat       = in_data.pattern;
		cell_d.fg = fg_mean;
		cell_d.bg = bg_mean;
		if (in_data.fg_n == 3'd0) begin
			cell_d.fg = bg_mean;
			pat       = qgbq_pkg::PatNone;
		end
		if (in_data.bg_n == 3'd0) begin
			cell_d.bg = fg_mean;
			pat       = qgbq_pkg::PatFull;
		end
		cell_d.pattern = pat;
		cell_d.glyph   = qgbq_pkg::glyph_of(pat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (in_ready) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s5 <= cell_d;
		end
	end

	assign out_valid = valid_s5;
	assign out_data  = data_s5;

endmodule

@@ src/quadrant_glyph_block_quantizer.sv @@
// ----------------------------------------------------------------------------
// quadrant_glyph_block_quantizer
// Turns a 2x2 RGB pixel block into one two-color quadrant character cell.
//
//   Channel  Dir  Payload
//   s_*      in   four 24-bit pixels TL, TR, BL, BR, 4-bit valid mask
//   m_*      out  glyph code, pattern, foreground RGB, background RGB
//
// Five register stages: luma weighting, masked sum, mean division, group
// split, group means with glyph lookup. One block enters per cycle unless
// m_tready stalls a full pipeline; results leave from the fifth register.
// Blocks with an empty mask are accepted and give no result.
// Reset clears the stage valid bits only. Each stage holds while its
// successor is full and stalled, so bubbles are squeezed out under stalls.
// ----------------------------------------------------------------------------
module quadrant_glyph_block_quantizer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// top_left_rgb, top_right_rgb, bottom_left_rgb, bottom_right_rgb,
	// valid_mask, zero fill
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// glyph_code, pattern_bits, fg_red, fg_green, fg_blue,
	// bg_red, bg_green, bg_blue, zero fill
	output logic [71:0]  m_tdata
);

	qgbq_pkg::luma_t  luma;
	qgbq_pkg::mean_t  mean;
	qgbq_pkg::split_t split;
	qgbq_pkg::cell_t  glyph_cell;
	logic             luma_valid, luma_ready;
	logic             mean_valid, mean_ready;
	logic             split_valid, split_ready;

	qgbq_luma u_luma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_px     (s_tdata[95:0]),
		.in_mask   (s_tdata[99:96]),
		.out_valid (luma_valid),
		.out_ready (luma_ready),
		.out_data  (luma)
	);

	qgbq_mean u_mean (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (luma_valid),
		.in_ready  (luma_ready),
		.in_data   (luma),
		.out_valid (mean_valid),
		.out_ready (mean_ready),
		.out_data  (mean)
	);

	qgbq_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mean_valid),
		.in_ready  (mean_ready),
		.in_data   (mean),
		.out_valid (split_valid),
		.out_ready (split_ready),
		.out_data  (split)
	);

	qgbq_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_valid),
		.in_ready  (split_ready),
		.in_data   (split),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (glyph_cell)
	);

	// pack the result transaction, first field lowest
	assign m_tdata = {6'd0,
		glyph_cell.bg.b, glyph_cell.bg.g, glyph_cell.bg.r,
		glyph_cell.fg.b, glyph_cell.fg.g, glyph_cell.fg.r,
		glyph_cell.pattern, glyph_cell.glyph};

endmodule
